// ----- design/assert_macros.svh -----
// shared assertion macros for the allocator checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only outside reset
`define FFPA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("allocator check failed");

// property checked at every edge, reset included
`define FFPA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("allocator check failed");

`endif

// ----- design/ffpa_pkg.sv -----
package ffpa_pkg;

  localparam int DEF_MAX_EXTENTS  = 16;
  localparam int DEF_HEADER_BYTES = 16;

  localparam int BASE_W   = 16;
  localparam int PAGES_W  = 17;
  localparam int ADDR_W   = 28;
  localparam int REQ_W    = 24;
  localparam int FPAGES_W = 16;
  localparam int SHIFT_W  = 5;
  localparam int BYTES_W  = 25;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [SHIFT_W-1:0]  RST_PAGE_SHIFT  = 5'd3;
  localparam logic [FPAGES_W-1:0] RST_TOTAL_PAGES = 16'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PAGES = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    WR_INIT,
    WR_COPY,
    WR_CARVE,
    WR_MERGE_PREV,
    WR_MERGE_BOTH,
    WR_MERGE_NEXT,
    WR_NEW
  } wr_sel_t;

  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [PAGES_W-1:0] pages;
  } ent_t;

  // controller to datapath
  typedef struct packed {
    logic    ld_req;
    logic    rd_en;
    logic    save_prev;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    res_ld;
    status_t res_status;
    logic    res_grant;
    logic    out_ld;
  } ffpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic need_ok;
    logic fit;
    logic carve_empty;
    logic le;
    logic fzero;
    logic touch_prev;
    logic touch_both;
    logic touch_next;
    logic cfg_load;
    logic cfg_nz;
  } ffpa_sts_t;

  function automatic logic [PAGES_W-1:0] sat_pages(input logic [PAGES_W:0] s);
    sat_pages = s[PAGES_W] ? {PAGES_W{1'b1}} : s[PAGES_W-1:0];
  endfunction

endpackage

// ----- design/ffpa_if.sv -----
interface ffpa_in_if import ffpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [REQ_W-1:0]    req_bytes;
  logic [ADDR_W-1:0]   free_base;
  logic [FPAGES_W-1:0] free_pages;
  modport source (output valid, opcode, req_bytes, free_base, free_pages, input ready);
  modport sink (input valid, opcode, req_bytes, free_base, free_pages, output ready);
endinterface

interface ffpa_out_if import ffpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [ADDR_W-1:0]   grant_base;
  logic [FPAGES_W-1:0] granted_pages;
  modport source (output valid, status, grant_base, granted_pages, input ready);
  modport sink (input valid, status, grant_base, granted_pages, output ready);
endinterface

interface ffpa_cfg_if import ffpa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/ffpa_ctrl.sv -----
module ffpa_ctrl import ffpa_pkg::*; #(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  ffpa_sts_t                      sts,
  output ffpa_cmd_t                      cmd,
  output logic [$clog2(MAX_EXTENTS)-1:0] rd_addr,
  output logic [$clog2(MAX_EXTENTS)-1:0] wr_addr
);

  localparam int AW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_EXTENTS);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISP, S_A_RD, S_A_CHK, S_SH_RD, S_SH_WR,
    S_F_RD, S_F_CHK, S_F_DEC, S_INS_RD, S_INS_WR, S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] idx_p1, idx_m1;

  assign idx_p1    = idx_r + 1'b1;
  assign idx_m1    = idx_r - 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    hi_nxt        = hi_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.wr_sel    = WR_COPY;
    cmd.res_status = ST_OK;
    rd_addr       = idx_r[AW-1:0];
    wr_addr       = idx_r[AW-1:0];
    case (state_r)
      S_INIT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_INIT;
        wr_addr    = '0;
        state_nxt  = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          idx_nxt    = '0;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: state_nxt = sts.is_free ? S_F_RD : S_A_RD;
      S_A_RD: begin
        if (!sts.need_ok || idx_r == cnt_r) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_NOFIT;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (sts.fit) begin
          // carve from the front, drop the entry if it empties
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = WR_CARVE;
          cmd.res_ld    = 1'b1;
          cmd.res_grant = 1'b1;
          state_nxt     = sts.carve_empty ? S_SH_RD : S_DONE;
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = S_A_RD;
        end
      end
      S_SH_RD: begin
        if (idx_p1 < cnt_r) begin
          cmd.rd_en = 1'b1;
          rd_addr   = idx_p1[AW-1:0];
          state_nxt = S_SH_WR;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SH_WR: begin
        cmd.wr_en = 1'b1;
        idx_nxt   = idx_p1;
        state_nxt = S_SH_RD;
      end
      S_F_RD: begin
        if (sts.fzero) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_DONE;
        end else if (idx_r == cnt_r) begin
          state_nxt = S_F_DEC;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (sts.le) begin
          cmd.save_prev = 1'b1;
          idx_nxt       = idx_p1;
          state_nxt     = S_F_RD;
        end else begin
          state_nxt = S_F_DEC;
        end
      end
      S_F_DEC: begin
        // idx is the first entry above the freed base
        cmd.res_ld = 1'b1;
        if (idx_r != '0 && sts.touch_prev) begin
          cmd.wr_en = 1'b1;
          wr_addr   = idx_m1[AW-1:0];
          if (idx_r != cnt_r && sts.touch_both) begin
            cmd.wr_sel = WR_MERGE_BOTH;
            state_nxt  = S_SH_RD;
          end else begin
            cmd.wr_sel = WR_MERGE_PREV;
            state_nxt  = S_DONE;
          end
        end else if (idx_r != cnt_r && sts.touch_next) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_MERGE_NEXT;
          state_nxt  = S_DONE;
        end else if (cnt_r == CNT_FULL) begin
          cmd.res_status = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          hi_nxt    = idx_r;
          idx_nxt   = cnt_r;
          state_nxt = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (idx_r > hi_r) begin
          cmd.rd_en = 1'b1;
          rd_addr   = idx_m1[AW-1:0];
          state_nxt = S_INS_WR;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_NEW;
          cnt_nxt    = cnt_r + 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_INS_WR: begin
        cmd.wr_en = 1'b1;
        idx_nxt   = idx_m1;
        state_nxt = S_INS_RD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (sts.cfg_load) cnt_nxt = sts.cfg_nz ? CW'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idx_r       <= '0;
      hi_r        <= '0;
      cnt_r       <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      hi_r        <= hi_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/ffpa_dp.sv -----
module ffpa_dp import ffpa_pkg::*; #(
  parameter int MAX_EXTENTS  = DEF_MAX_EXTENTS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_opcode,
  input  logic [REQ_W-1:0]               in_req_bytes,
  input  logic [ADDR_W-1:0]              in_free_base,
  input  logic [FPAGES_W-1:0]            in_free_pages,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  ffpa_cmd_t                      cmd,
  input  logic [$clog2(MAX_EXTENTS)-1:0] rd_addr,
  input  logic [$clog2(MAX_EXTENTS)-1:0] wr_addr,
  output ffpa_sts_t                      sts,
  output logic [1:0]                     out_status,
  output logic [ADDR_W-1:0]              out_grant_base,
  output logic [FPAGES_W-1:0]            out_granted_pages
);

  ent_t ext_mem_r [MAX_EXTENTS];
  ent_t rd_data_r, prev_r, wr_data;

  logic [SHIFT_W-1:0]  page_shift_r;
  logic [FPAGES_W-1:0] total_r;
  logic                is_free_r;
  logic                need_ok_r;
  logic [FPAGES_W-1:0] need_r;
  logic [BASE_W-1:0]   fbase_r;
  logic [FPAGES_W-1:0] fpages_r;
  status_t             res_status_r;
  logic [ADDR_W-1:0]   res_addr_r;
  logic [FPAGES_W-1:0] res_grant_r;
  status_t             out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [FPAGES_W-1:0] out_grant_r;

  logic [BYTES_W-1:0]  bytes, bytes_shr, need;
  logic                rem_nz;
  logic [ADDR_W-1:0]   fbase_shr;
  logic [PAGES_W-1:0]  sum_pf, sum_both, sum_next;
  logic                cfg_total_we;

  assign cfg_total_we = cfg_we && cfg_index == REG_TOTAL_PAGES;

  // round the byte count up to whole pages
  assign bytes     = {1'b0, in_req_bytes} + BYTES_W'(HEADER_BYTES);
  assign bytes_shr = bytes >> page_shift_r;
  assign rem_nz    = |(bytes & ~({BYTES_W{1'b1}} << page_shift_r));
  assign need      = bytes_shr + BYTES_W'(rem_nz);
  assign fbase_shr = in_free_base >> page_shift_r;

  assign sum_pf   = sat_pages({1'b0, prev_r.pages} + {2'b0, fpages_r});
  assign sum_both = sat_pages({1'b0, sum_pf} + {1'b0, rd_data_r.pages});
  assign sum_next = sat_pages({1'b0, rd_data_r.pages} + {2'b0, fpages_r});

  always_comb begin
    case (cmd.wr_sel)
      WR_INIT:       wr_data = '{base: '0, pages: {1'b0, total_r}};
      WR_COPY:       wr_data = rd_data_r;
      WR_CARVE:      wr_data = '{base: rd_data_r.base + need_r,
                                 pages: rd_data_r.pages - {1'b0, need_r}};
      WR_MERGE_PREV: wr_data = '{base: prev_r.base, pages: sum_pf};
      WR_MERGE_BOTH: wr_data = '{base: prev_r.base, pages: sum_both};
      WR_MERGE_NEXT: wr_data = '{base: fbase_r, pages: sum_next};
      WR_NEW:        wr_data = '{base: fbase_r, pages: {1'b0, fpages_r}};
      default:       wr_data = rd_data_r;
    endcase
  end

  always_comb begin
    sts.is_free     = is_free_r;
    sts.need_ok     = need_ok_r;
    sts.fit         = rd_data_r.pages >= {1'b0, need_r};
    sts.carve_empty = rd_data_r.pages == {1'b0, need_r};
    sts.le          = rd_data_r.base <= fbase_r;
    sts.fzero       = fpages_r == '0;
    sts.touch_prev  = ({2'b0, prev_r.base} + {1'b0, prev_r.pages}) == {2'b0, fbase_r};
    sts.touch_both  = ({2'b0, prev_r.base} + {1'b0, sum_pf}) == {2'b0, rd_data_r.base};
    sts.touch_next  = {1'b0, rd_data_r.base} == ({1'b0, fbase_r} + {1'b0, fpages_r});
    sts.cfg_load    = cfg_total_we;
    sts.cfg_nz      = cfg_data[FPAGES_W-1:0] != '0;
  end

  always_ff @(posedge clk) begin
    if (cfg_total_we) begin
      ext_mem_r[0] <= '{base: '0, pages: {1'b0, cfg_data[FPAGES_W-1:0]}};
    end else if (cmd.wr_en) begin
      ext_mem_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) rd_data_r <= ext_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r <= RST_PAGE_SHIFT;
      total_r      <= RST_TOTAL_PAGES;
    end else if (cfg_we) begin
      if (cfg_index == REG_PAGE_SHIFT) page_shift_r <= cfg_data[SHIFT_W-1:0];
      if (cfg_index == REG_TOTAL_PAGES) total_r <= cfg_data[FPAGES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      is_free_r <= in_opcode == OP_FREE;
      need_ok_r <= need != '0 && need[BYTES_W-1:FPAGES_W] == '0;
      need_r    <= need[FPAGES_W-1:0];
      fbase_r   <= fbase_shr[BASE_W-1:0];
      fpages_r  <= in_free_pages;
    end
    if (cmd.save_prev) prev_r <= rd_data_r;
    if (cmd.res_ld) begin
      res_status_r <= cmd.res_status;
      res_addr_r   <= cmd.res_grant ? ADDR_W'(rd_data_r.base) << page_shift_r : '0;
      res_grant_r  <= cmd.res_grant ? need_r : '0;
    end
    if (cmd.out_ld) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_grant_r  <= res_grant_r;
    end
  end

  assign out_status        = out_status_r;
  assign out_grant_base    = out_addr_r;
  assign out_granted_pages = out_grant_r;

endmodule

// ----- design/first_fit_page_allocator.sv -----
// First-fit page allocator for one page-size class.
// in_chan carries one request per transfer: opcode 0 allocates req_bytes plus
// a header, rounded up to pages; opcode 1 returns free_pages pages at byte
// offset free_base, merged with touching free extents or inserted in order.
// out_chan returns one result per request: status, grant_base and
// granted_pages. cfg_chan writes page_shift (index 0) and total_pages
// (index 1); a total_pages write reloads the table as one free extent.
// A request runs an ordered scan of the extents, a step that closes the scan
// or decides a free, and, when an extent is removed or inserted, a move of
// each entry behind it. One request is in flight at a time and the next is
// taken from the cycle its result is offered; all work goes through a
// single-port extent memory (one read or one write per cycle), which sets
// the rate.
// After reset, S_INIT loads the initial extent, then in_chan.ready rises.
// A result waiting on a stalled receiver does not block the next request;
// that request finishes into a holding register and waits for out_chan.
module first_fit_page_allocator import ffpa_pkg::*; #(
  parameter int MAX_EXTENTS  = DEF_MAX_EXTENTS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  ffpa_in_if.sink     in_chan,
  ffpa_out_if.source  out_chan,
  ffpa_cfg_if.sink    cfg_chan
);

  localparam int AW = $clog2(MAX_EXTENTS);

  ffpa_cmd_t     cmd;
  ffpa_sts_t     sts;
  logic [AW-1:0] rd_addr, wr_addr;

  assign cfg_chan.ready = 1'b1;

  ffpa_ctrl #(.MAX_EXTENTS(MAX_EXTENTS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr)
  );

  ffpa_dp #(.MAX_EXTENTS(MAX_EXTENTS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_opcode         (in_chan.opcode),
    .in_req_bytes      (in_chan.req_bytes),
    .in_free_base      (in_chan.free_base),
    .in_free_pages     (in_chan.free_pages),
    .cfg_we            (cfg_chan.valid),
    .cfg_index         (cfg_chan.index),
    .cfg_data          (cfg_chan.data),
    .cmd               (cmd),
    .rd_addr           (rd_addr),
    .wr_addr           (wr_addr),
    .sts               (sts),
    .out_status        (out_chan.status),
    .out_grant_base    (out_chan.grant_base),
    .out_granted_pages (out_chan.granted_pages)
  );

endmodule

// ----- design/ffpa_checker.sv -----
`include "assert_macros.svh"

module ffpa_checker import ffpa_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [1:0]          out_status,
  input logic [ADDR_W-1:0]   out_grant_base,
  input logic [FPAGES_W-1:0] out_granted_pages
);

  // no result is offered right after reset
  `FFPA_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid)

  // a failed request grants nothing
  `FFPA_ASSERT(a_fail_zero, clk, rst_n,
    out_valid && out_status != ST_OK |-> out_grant_base == '0 && out_granted_pages == '0)

  // pages granted only with an ok status
  `FFPA_ASSERT(a_grant_ok, clk, rst_n,
    out_valid && out_granted_pages != '0 |-> out_status == ST_OK)

  // a stalled result stays offered
  `FFPA_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_status        (out_chan.status),
  .out_grant_base    (out_chan.grant_base),
  .out_granted_pages (out_chan.granted_pages)
);
